// ===== src/lpjd_pkg.sv =====
`default_nettype none
package lpjd_pkg;

    localparam int LANES    = 3;
    localparam int LANE_W   = 2;
    localparam int TAG_W    = 16;
    localparam int PRIO_W   = 16;
    localparam int ENTRY_W  = PRIO_W + TAG_W;
    localparam int LIMIT_W  = 4;
    localparam int REMOVE_W = 9;
    localparam int DROP_W   = 32;

    localparam logic [1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [1:0] REQ_FINISH  = 2'd1;
    localparam logic [1:0] REQ_CANCEL  = 2'd2;

    localparam logic [2:0] EV_ACCEPTED    = 3'd0;
    localparam logic [2:0] EV_DROPPED     = 3'd1;
    localparam logic [2:0] EV_DISPATCHED  = 3'd2;
    localparam logic [2:0] EV_FINISH_ACK  = 3'd3;
    localparam logic [2:0] EV_CANCEL_DONE = 3'd4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET [LANES] = '{4'd3, 4'd2, 4'd1};

    typedef struct packed {
        logic [1:0]               req_type;
        logic [LANE_W-1:0]        lane;
        logic [TAG_W-1:0]         job_tag;
        logic signed [PRIO_W-1:0] job_priority;
    } t_in_req;

    typedef struct packed {
        logic [2:0]          event_kind;
        logic [LANE_W-1:0]   event_lane;
        logic [TAG_W-1:0]    event_tag;
        logic [REMOVE_W-1:0] removed_count;
        logic [DROP_W-1:0]   drop_total;
        logic                last_of_run;
    } t_out_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ_START,
        S_ENQ_CMP,
        S_FIN,
        S_DISP_CHK,
        S_DISP_TAKE,
        S_CAN_LANE,
        S_CAN_CMP,
        S_EMIT1,
        S_EMIT2
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DROP,
        OP_ENQ_START,
        OP_SHIFT,
        OP_PLACE,
        OP_FIN,
        OP_DISP_CHK,
        OP_DISP_TAKE,
        OP_CAN_SKIP,
        OP_CAN_FIRST,
        OP_CAN_STEP,
        OP_EMIT1,
        OP_EMIT2
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic enq_reject;
        logic shift;
        logic disp;
        logic lane_end;
        logic lane_empty;
        logic can_last;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== src/lpjd_ram.sv =====
`default_nettype none
module lpjd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/lpjd_datapath.sv =====
`default_nettype none
module lpjd_datapath
    import lpjd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 128
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_sts                  o_sts,
    input  wire t_in_req             i_in_req,
    output t_out_res                 o_out_res,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    input  wire logic                i_cfg_valid,
    input  wire logic [LANE_W-1:0]   i_cfg_index,
    input  wire logic [LIMIT_W-1:0]  i_cfg_data
);
    localparam int DEPTH_ALL = LANES * QUEUE_DEPTH;
    localparam int AW = $clog2(DEPTH_ALL);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    t_in_req              r_req;
    logic [LANE_W-1:0]    r_lane;
    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_w;
    logic [REMOVE_W-1:0]  r_removed;
    logic                 r_disp;
    logic [2:0]           r_kind1;
    logic [TAG_W-1:0]     r_dtag;
    logic [CW-1:0]        r_cnt   [LANES];
    logic [LIMIT_W-1:0]   r_run   [LANES];
    logic [IW-1:0]        r_head  [LANES];
    logic [LIMIT_W-1:0]   r_limit [LANES];
    logic [DROP_W-1:0]    r_drop;
    t_out_res             r_out;
    logic                 r_out_valid;

    logic                 l_lane_ok;
    logic [CW-1:0]        l_cnt;
    logic [LIMIT_W-1:0]   l_run;
    logic [LIMIT_W-1:0]   l_limit;
    logic [IW-1:0]        l_head;
    logic                 l_match;
    logic [CW-1:0]        l_w_next;
    logic                 l_we;
    logic [CW-1:0]        l_wlog;
    logic [CW-1:0]        l_rlog;
    logic [ENTRY_W-1:0]   l_wdata;
    logic [ENTRY_W-1:0]   l_rdata;
    logic [AW-1:0]        l_waddr;
    logic [AW-1:0]        l_raddr;
    logic                 l_out_free;
    logic                 l_emit;

    // lane base plus circular offset from the lane's head
    function automatic logic [AW-1:0] phys(input logic [LANE_W-1:0] lane,
                                          input logic [IW-1:0] head,
                                          input logic [CW-1:0] lg);
        logic [CW:0] s;
        logic [CW:0] w;
        s = (CW+1)'(head) + (CW+1)'(lg);
        w = (s >= (CW+1)'(QUEUE_DEPTH)) ? s - (CW+1)'(QUEUE_DEPTH) : s;
        return AW'(lane) * AW'(QUEUE_DEPTH) + AW'(w);
    endfunction

    assign l_lane_ok  = int'(r_lane) < LANES;
    assign l_cnt      = l_lane_ok ? r_cnt[r_lane]   : '0;
    assign l_run      = l_lane_ok ? r_run[r_lane]   : '0;
    assign l_limit    = l_lane_ok ? r_limit[r_lane] : '0;
    assign l_head     = l_lane_ok ? r_head[r_lane]  : '0;
    assign l_match    = l_rdata[TAG_W-1:0] == r_req.job_tag;
    assign l_w_next   = l_match ? r_w : r_w + CW'(1);
    assign l_out_free = !r_out_valid || i_out_ready;
    assign l_emit     = (i_cmd.op == OP_EMIT1) || (i_cmd.op == OP_EMIT2);

    always_comb begin
        l_we    = 1'b0;
        l_wlog  = r_idx;
        l_wdata = l_rdata;
        l_rlog  = '0;
        unique case (i_cmd.op)
            OP_ENQ_START: l_rlog = l_cnt - CW'(1);
            OP_SHIFT: begin
                l_we   = 1'b1;
                l_rlog = r_idx - CW'(2);
            end
            OP_PLACE: begin
                l_we    = 1'b1;
                l_wdata = {r_req.job_priority, r_req.job_tag};
            end
            OP_CAN_STEP: begin
                l_we   = !l_match;
                l_wlog = r_w;
                l_rlog = r_idx + CW'(1);
            end
            default: l_rlog = '0;
        endcase
    end

    assign l_waddr = phys(r_lane, l_head, l_wlog);
    assign l_raddr = phys(r_lane, l_head, l_rlog);

    lpjd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH_ALL)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    always_comb begin
        o_sts.enq_reject = !l_lane_ok || (l_cnt >= CW'(QUEUE_DEPTH));
        o_sts.shift      = (r_idx != '0) &&
                           ($signed(l_rdata[ENTRY_W-1:TAG_W]) < r_req.job_priority);
        o_sts.disp       = r_disp;
        o_sts.lane_end   = !l_lane_ok;
        o_sts.lane_empty = l_cnt == '0;
        o_sts.can_last   = (r_idx + CW'(1)) == l_cnt;
        o_sts.out_free   = l_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LANES; l++) begin
                r_cnt[l]   <= '0;
                r_run[l]   <= '0;
                r_head[l]  <= '0;
                r_limit[l] <= LIMIT_RESET[l];
            end
            r_drop      <= '0;
            r_out_valid <= 1'b0;
            r_disp      <= 1'b0;
        end else begin
            if (i_cfg_valid && int'(i_cfg_index) < LANES) begin
                r_limit[i_cfg_index] <= i_cfg_data;
            end
            if (i_out_ready && !l_emit) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_req     <= i_in_req;
                    r_lane    <= (i_in_req.req_type == REQ_CANCEL) ? '0 : i_in_req.lane;
                    r_removed <= '0;
                    r_disp    <= 1'b0;
                    priority case (i_in_req.req_type)
                        REQ_ENQUEUE: r_kind1 <= EV_ACCEPTED;
                        REQ_FINISH:  r_kind1 <= EV_FINISH_ACK;
                        default:     r_kind1 <= EV_CANCEL_DONE;
                    endcase
                end
                OP_DROP: begin
                    if (r_drop != '1) begin
                        r_drop <= r_drop + DROP_W'(1);
                    end
                    r_kind1 <= EV_DROPPED;
                end
                OP_ENQ_START: r_idx <= l_cnt;
                OP_SHIFT:     r_idx <= r_idx - CW'(1);
                OP_PLACE:     r_cnt[r_lane] <= l_cnt + CW'(1);
                OP_FIN: begin
                    if (l_lane_ok && l_run != '0) begin
                        r_run[r_lane] <= l_run - LIMIT_W'(1);
                    end
                end
                OP_DISP_CHK: r_disp <= l_lane_ok && (l_cnt != '0) && (l_run < l_limit);
                OP_DISP_TAKE: begin
                    if (r_disp) begin
                        r_dtag         <= l_rdata[TAG_W-1:0];
                        r_head[r_lane] <= (int'(l_head) == QUEUE_DEPTH - 1) ? '0
                                          : l_head + IW'(1);
                        r_cnt[r_lane]  <= l_cnt - CW'(1);
                        r_run[r_lane]  <= l_run + LIMIT_W'(1);
                    end
                end
                OP_CAN_SKIP: r_lane <= r_lane + LANE_W'(1);
                OP_CAN_FIRST: begin
                    r_idx <= '0;
                    r_w   <= '0;
                end
                OP_CAN_STEP: begin
                    r_idx <= r_idx + CW'(1);
                    r_w   <= l_w_next;
                    if (l_match) begin
                        r_removed <= r_removed + REMOVE_W'(1);
                    end
                    if ((r_idx + CW'(1)) == l_cnt) begin
                        r_cnt[r_lane] <= l_w_next;
                        r_lane        <= r_lane + LANE_W'(1);
                    end
                end
                OP_EMIT1: begin
                    r_out_valid         <= 1'b1;
                    r_out.event_kind    <= r_kind1;
                    r_out.event_lane    <= (r_kind1 == EV_CANCEL_DONE) ? '0 : r_req.lane;
                    r_out.event_tag     <= (r_kind1 == EV_FINISH_ACK) ? '0 : r_req.job_tag;
                    r_out.removed_count <= r_removed;
                    r_out.drop_total    <= r_drop;
                    r_out.last_of_run   <= !r_disp;
                end
                OP_EMIT2: begin
                    r_out_valid         <= 1'b1;
                    r_out.event_kind    <= EV_DISPATCHED;
                    r_out.event_lane    <= r_req.lane;
                    r_out.event_tag     <= r_dtag;
                    r_out.removed_count <= '0;
                    r_out.drop_total    <= r_drop;
                    r_out.last_of_run   <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_res   = r_out;
    assign o_out_valid = r_out_valid;

    a_place_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_PLACE |-> l_cnt < CW'(QUEUE_DEPTH))
        else $error("insert into a full lane");

    a_removed_only_cancel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.event_kind != EV_CANCEL_DONE |-> r_out.removed_count == '0)
        else $error("removed count on a non-cancel event");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_EMIT1 || i_cmd.op == OP_EMIT2) |-> l_out_free)
        else $error("result overwrites a waiting result");

endmodule
`default_nettype wire

// ===== src/lpjd_ctrl.sv =====
`default_nettype none
module lpjd_ctrl
    import lpjd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_req_type,
    output logic            o_in_ready,
    output t_dp_cmd         o_cmd,
    input  wire t_dp_sts    i_sts
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    priority case (i_req_type)
                        REQ_ENQUEUE: n_state = S_ENQ_START;
                        REQ_FINISH:  n_state = S_FIN;
                        REQ_CANCEL:  n_state = S_CAN_LANE;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_ENQ_START: begin
                if (i_sts.enq_reject) begin
                    o_cmd.op = OP_DROP;
                    n_state  = S_EMIT1;
                end else begin
                    o_cmd.op = OP_ENQ_START;
                    n_state  = S_ENQ_CMP;
                end
            end
            S_ENQ_CMP: begin
                if (i_sts.shift) begin
                    o_cmd.op = OP_SHIFT;
                end else begin
                    o_cmd.op = OP_PLACE;
                    n_state  = S_DISP_CHK;
                end
            end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                n_state  = S_DISP_CHK;
            end
            S_DISP_CHK: begin
                o_cmd.op = OP_DISP_CHK;
                n_state  = S_DISP_TAKE;
            end
            S_DISP_TAKE: begin
                o_cmd.op = OP_DISP_TAKE;
                n_state  = S_EMIT1;
            end
            S_CAN_LANE: begin
                if (i_sts.lane_end) begin
                    n_state = S_EMIT1;
                end else if (i_sts.lane_empty) begin
                    o_cmd.op = OP_CAN_SKIP;
                end else begin
                    o_cmd.op = OP_CAN_FIRST;
                    n_state  = S_CAN_CMP;
                end
            end
            S_CAN_CMP: begin
                o_cmd.op = OP_CAN_STEP;
                if (i_sts.can_last) begin
                    n_state = S_CAN_LANE;
                end
            end
            S_EMIT1: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT1;
                    n_state  = i_sts.disp ? S_EMIT2 : S_IDLE;
                end
            end
            S_EMIT2: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT2;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_emit2_after_emit1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT2 |-> $past(r_state) == S_EMIT1 || $past(r_state) == S_EMIT2)
        else $error("dispatch result without first result");

    a_emit2_needs_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT1 && i_sts.out_free && !i_sts.disp |=> r_state == S_IDLE)
        else $error("second result without dispatch");

endmodule
`default_nettype wire

// ===== src/lane_priority_job_dispatcher_top.sv =====
// three-lane job dispatcher with per-lane priority queues and run limits
// input channel (i_in_valid/o_in_ready, i_in_req): one request a time, taken
//   only while the block is idle; type enqueue, finish or cancel
// output channel (o_out_valid/i_out_ready, o_out_res): one or two results per
//   request, last_of_run marks the final one; an output register holds each
//   result until taken, and the block waits while the receiver stalls
// config channel (i_cfg_valid/o_cfg_ready): always ready, writes run limits
// per request: enqueue checks the lane, then a sorted insert walks from the
//   tail one entry a cycle and places the job, or a dropped one goes straight
//   to its result; finish lowers the lane's running count; both then check
//   for a dispatch, which adds a second result; cancel walks every entry of
//   every lane; the longest request is a cancel with every lane full, set by
// the walk through the shared pending store (one read and one write per cycle);
// the next request can be taken once the last result is at the output
// reset: counts, running counts, drop counter clear, limits go to 3, 2, 1;
// the pending store needs no clearing pass
`default_nettype none
module lane_priority_job_dispatcher_top
    import lpjd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 128
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_req            i_in_req,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_res                o_out_res,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [LANE_W-1:0]  i_cfg_index,
    input  wire logic [LIMIT_W-1:0] i_cfg_data
);
    t_dp_cmd l_cmd;
    t_dp_sts l_sts;

    assign o_cfg_ready = 1'b1;

    lpjd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_req.req_type),
        .o_in_ready (o_in_ready),
        .o_cmd      (l_cmd),
        .i_sts      (l_sts)
    );

    lpjd_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (l_cmd),
        .o_sts       (l_sts),
        .i_in_req    (i_in_req),
        .o_out_res   (o_out_res),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );
endmodule
`default_nettype wire
